FILE: src/keyed_node_table_with_aging_assert.svh
// assertion macros for the keyed node table
// each check is sampled on the rising clock and switched off while in reset
`ifndef KEYED_NODE_TABLE_WITH_AGING_ASSERT_SVH
`define KEYED_NODE_TABLE_WITH_AGING_ASSERT_SVH

// condition must hold at every clock edge
`define KNTAB_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// when the trigger holds, the consequence must hold in the next clock cycle
`define KNTAB_ASSERT_NEXT(name, trig, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/kntab_pkg.sv
package kntab_pkg;

    // table geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // field widths
    localparam int BYTE_W    = 8;
    localparam int KEY_W     = 5 * BYTE_W;
    localparam int TIME_W    = 32;
    localparam int RAM_W     = KEY_W + TIME_W;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 4;
    localparam int EXPIRED_W = 5;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd5000;

    // request codes
    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_SWEEP  = 1'b1;

    // result codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_FOUND = 2'd0,
        STATUS_ALLOC = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_SWEEP = 2'd3
    } status_t;

endpackage

FILE: src/kntab_ram.sv
module kntab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/keyed_node_table_with_aging.sv
// keyed node table with aging: a small associative table of ENTRIES entries
// (16 here) keyed by five key bytes. a lookup item (action 0) returns the
// slot of the matching valid entry, or claims the lowest free entry, stores
// the key and stamps it with now_ms, or reports the table full. a sweep item
// (action 1) frees every valid entry whose wrapping age now_ms - stamp is
// strictly greater than timeout_ms and reports how many it freed. found
// entries are not re-stamped. an item is taken when start is high and busy is
// low; busy then stays high while a sequencer walks the entries one per clock
// through a single key comparator and a single age subtract-and-compare. keys
// and stamps sit in a ram with registered read that the compare trails; a
// finish state then writes an allocated entry and posts the result. done is
// high for exactly one cycle; status, slot and expired_count hold the result
// until the next one, and the receiver cannot stall it. timeout_ms is written
// through cfg_valid / cfg_data (cfg_ready is always high); the user must do so
// only while no item is in flight, which the block does not enforce. it
// resets to 5000. the valid bits clear at reset, no clearing pass.
module keyed_node_table_with_aging (
    input  logic                                clk,
    input  logic                                rst_n,
    // command side
    input  logic                                start,
    output logic                                busy,
    input  logic                                action,
    input  logic [kntab_pkg::BYTE_W-1:0]        wing_key,
    input  logic [kntab_pkg::BYTE_W-1:0]        room_key,
    input  logic [kntab_pkg::BYTE_W-1:0]        bed_key,
    input  logic [kntab_pkg::BYTE_W-1:0]        patient_key,
    input  logic [kntab_pkg::BYTE_W-1:0]        kind_key,
    input  logic [kntab_pkg::TIME_W-1:0]        now_ms,
    // result side
    output logic                                done,
    output logic [kntab_pkg::STATUS_W-1:0]      status,
    output logic [kntab_pkg::SLOT_W-1:0]        slot,
    output logic [kntab_pkg::EXPIRED_W-1:0]     expired_count,
    // timeout register write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kntab_pkg::TIME_W-1:0]        cfg_data
);

    import kntab_pkg::*;

    `include "keyed_node_table_with_aging_assert.svh"

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // latched item
    logic              action_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [TIME_W-1:0] now_reg;

    // configuration
    logic [TIME_W-1:0] timeout_reg;

    // walk counters: scan_idx issues ram reads, cmp_idx trails it by one
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             cmp_vld_reg, cmp_vld_next;

    // walk results
    logic             hit_found_reg, hit_found_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // entry valid bits
    logic [ENTRIES-1:0] valid_reg, valid_next;

    // result registers
    logic                 done_reg, done_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [EXPIRED_W-1:0] expired_reg, expired_next;

    // ram port
    logic             ram_rd_en;
    logic             ram_wr_en;
    logic [RAM_W-1:0] ram_rd_data;
    logic [RAM_W-1:0] ram_wr_data;

    // shared compare unit operands
    logic [KEY_W-1:0]  ent_key;
    logic [TIME_W-1:0] ent_stamp;
    logic [TIME_W-1:0] ent_age;
    logic              ent_valid;
    logic              key_match;
    logic              aged_out;
    logic              scan_issue;
    logic              cmp_last;
    logic              accept;

    assign accept     = start && (state_reg == ST_IDLE);
    assign busy       = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;

    assign ent_key    = ram_rd_data[RAM_W-1:TIME_W];
    assign ent_stamp  = ram_rd_data[TIME_W-1:0];
    assign ent_valid  = valid_reg[cmp_idx_reg];
    assign ent_age    = now_reg - ent_stamp;
    assign key_match  = (ent_key == key_reg);
    assign aged_out   = (ent_age > timeout_reg);

    assign scan_issue = (state_reg == ST_SCAN) && (scan_idx_reg < CNT_W'(ENTRIES));
    assign cmp_last   = cmp_vld_reg && (cmp_idx_reg == IDX_W'(ENTRIES - 1));

    assign ram_rd_en   = scan_issue;
    assign ram_wr_en   = (state_reg == ST_FINISH) && (action_reg == ACT_LOOKUP)
                         && !hit_found_reg && free_found_reg;
    assign ram_wr_data = {key_reg, now_reg};

    kntab_ram #(
        .WIDTH (RAM_W),
        .DEPTH (ENTRIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (free_idx_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (scan_idx_reg[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    // sequencer and walk
    always_comb
    begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_vld_next    = 1'b0;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        count_next      = count_reg;
        valid_next      = valid_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        slot_next       = slot_reg;
        expired_next    = expired_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next      = ST_SCAN;
                    scan_idx_next   = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    hit_idx_next    = '0;
                    free_idx_next   = '0;
                    count_next      = '0;
                end
            end

            ST_SCAN:
            begin
                // issue the next read while the previous entry is compared
                if (scan_issue)
                begin
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next = scan_idx_reg + 1'b1;
                end

                if (cmp_vld_reg)
                begin
                    if (action_reg == ACT_SWEEP)
                    begin
                        if (ent_valid && aged_out)
                        begin
                            valid_next[cmp_idx_reg] = 1'b0;
                            count_next              = count_reg + 1'b1;
                        end
                    end
                    else if (ent_valid)
                    begin
                        if (!hit_found_reg && key_match)
                        begin
                            hit_found_next = 1'b1;
                            hit_idx_next   = cmp_idx_reg;
                        end
                    end
                    else if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = cmp_idx_reg;
                    end
                end

                if (cmp_last)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                state_next   = ST_IDLE;
                done_next    = 1'b1;
                slot_next    = '0;
                expired_next = '0;
                if (action_reg == ACT_SWEEP)
                begin
                    status_next  = STATUS_SWEEP;
                    expired_next = EXPIRED_W'(count_reg);
                end
                else if (hit_found_reg)
                begin
                    status_next = STATUS_FOUND;
                    slot_next   = SLOT_W'(hit_idx_reg);
                end
                else if (free_found_reg)
                begin
                    // claim the lowest free entry; key and stamp go to the ram
                    status_next               = STATUS_ALLOC;
                    slot_next                 = SLOT_W'(free_idx_reg);
                    valid_next[free_idx_reg]  = 1'b1;
                end
                else
                begin
                    status_next = STATUS_FULL;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_idx_reg   <= '0;
            cmp_idx_reg    <= '0;
            cmp_vld_reg    <= 1'b0;
            hit_found_reg  <= 1'b0;
            hit_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            count_reg      <= '0;
            valid_reg      <= '0;
            done_reg       <= 1'b0;
            timeout_reg    <= TIMEOUT_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            scan_idx_reg   <= scan_idx_next;
            cmp_idx_reg    <= cmp_idx_next;
            cmp_vld_reg    <= cmp_vld_next;
            hit_found_reg  <= hit_found_next;
            hit_idx_reg    <= hit_idx_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            count_reg      <= count_next;
            valid_reg      <= valid_next;
            done_reg       <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                timeout_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            key_reg    <= {wing_key, room_key, bed_key, patient_key, kind_key};
            now_reg    <= now_ms;
        end
        status_reg  <= status_next;
        slot_reg    <= slot_next;
        expired_reg <= expired_next;
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign slot          = slot_reg;
    assign expired_count = expired_reg;

    // checks
    `KNTAB_ASSERT_NEXT(a_accept_starts_walk, accept, state_reg == ST_SCAN, "item not walked")
    `KNTAB_ASSERT_NEXT(a_finish_posts_result, state_reg == ST_FINISH, done_reg && !busy, "no result after walk")
    `KNTAB_ASSERT_ALWAYS(a_done_only_idle, !done_reg || state_reg == ST_IDLE, "result outside idle")
    `KNTAB_ASSERT_ALWAYS(a_count_bounded, count_reg <= CNT_W'(ENTRIES), "freed count too large")
    `KNTAB_ASSERT_ALWAYS(a_sweep_slot_zero, !(done_reg && status_reg == STATUS_SWEEP) || slot_reg == '0, "sweep slot not zero")

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

import kntab_pkg::*;

// one command as it goes onto the request ports
typedef struct packed {
    logic                 action;
    logic [BYTE_W-1:0]    wing_key;
    logic [BYTE_W-1:0]    room_key;
    logic [BYTE_W-1:0]    bed_key;
    logic [BYTE_W-1:0]    patient_key;
    logic [BYTE_W-1:0]    kind_key;
    logic [TIME_W-1:0]    now_ms;
} table_request_t;

// one result as it shows on the result ports
typedef struct packed {
    status_t              status;
    logic [SLOT_W-1:0]    slot;
    logic [EXPIRED_W-1:0] expired_count;
} table_result_t;

// mirror of the node table plus the results still owed by the block
class table_scoreboard;
    logic                 live       [ENTRIES];
    logic [KEY_W-1:0]     stored_key [ENTRIES];
    logic [TIME_W-1:0]    stamp      [ENTRIES];
    logic [TIME_W-1:0]    timeout_ms;
    table_result_t        pending_results [$];
    int                   errors;

    function new();
        for (int i = 0; i < ENTRIES; i++)
        begin
            live[i]       = 1'b0;
            stored_key[i] = '0;
            stamp[i]      = '0;
        end
        timeout_ms = TIMEOUT_RESET;
        errors     = 0;
    endfunction

    function void set_timeout(input logic [TIME_W-1:0] value);
        timeout_ms = value;
    endfunction

    // apply an accepted item to the mirror and queue the result it must give
    function void note_request(input table_request_t req);
        table_result_t        res;
        logic [KEY_W-1:0]     want;
        logic [TIME_W-1:0]    age;
        int                   hit;
        int                   vacant;
        int                   freed;
        res    = '0;
        hit    = -1;
        vacant = -1;
        freed  = 0;
        if (req.action == ACT_SWEEP)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                age = req.now_ms - stamp[i];
                if (live[i] && age > timeout_ms)
                begin
                    live[i] = 1'b0;
                    freed++;
                end
            end
            res.status        = STATUS_SWEEP;
            res.expired_count = EXPIRED_W'(freed);
        end
        else
        begin
            want = {req.wing_key, req.room_key, req.bed_key, req.patient_key, req.kind_key};
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (live[i])
                begin
                    if (hit < 0 && stored_key[i] == want)
                        hit = i;
                end
                else if (vacant < 0)
                    vacant = i;
            end
            if (hit >= 0)
            begin
                res.status = STATUS_FOUND;
                res.slot   = SLOT_W'(hit);
            end
            else if (vacant >= 0)
            begin
                live[vacant]       = 1'b1;
                stored_key[vacant] = want;
                stamp[vacant]      = req.now_ms;
                res.status         = STATUS_ALLOC;
                res.slot           = SLOT_W'(vacant);
            end
            else
                res.status = STATUS_FULL;
        end
        pending_results.push_back(res);
    endfunction

    task report_mismatch(input string what);
        errors++;
        if (errors <= 100)
            $display("tb: mismatch #%0d at %0t: %s", errors, $realtime, what);
    endtask

    task check_result(input logic [STATUS_W-1:0] got_status,
                      input logic [SLOT_W-1:0] got_slot,
                      input logic [EXPIRED_W-1:0] got_count);
        table_result_t exp;
        if (pending_results.size() == 0)
        begin
            report_mismatch("result with no item outstanding");
            return;
        end
        exp = pending_results.pop_front();
        if (got_status !== exp.status)
            report_mismatch($sformatf("status %0d, expected %0d", got_status, exp.status));
        if (got_slot !== exp.slot)
            report_mismatch($sformatf("slot %0d, expected %0d", got_slot, exp.slot));
        if (got_count !== exp.expired_count)
            report_mismatch($sformatf("expired_count %0d, expected %0d",
                                      got_count, exp.expired_count));
    endtask
endclass

module tb;

    // cycles with no handshake of any kind before the run is abandoned
    localparam int STALL_LIMIT = 2000;
    // size of the key pool that random lookups draw from, larger than the table
    localparam int POOL        = 24;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  action = ACT_LOOKUP;
    logic [BYTE_W-1:0]     wing_key = '0;
    logic [BYTE_W-1:0]     room_key = '0;
    logic [BYTE_W-1:0]     bed_key = '0;
    logic [BYTE_W-1:0]     patient_key = '0;
    logic [BYTE_W-1:0]     kind_key = '0;
    logic [TIME_W-1:0]     now_ms = '0;
    logic                  done;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_W-1:0]     slot;
    logic [EXPIRED_W-1:0]  expired_count;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [TIME_W-1:0]     cfg_data = '0;

    table_scoreboard       sb;
    int                    stall_cycles = 0;
    logic [KEY_W-1:0]      key_pool [POOL];
    logic [TIME_W-1:0]     clock_ms;

    keyed_node_table_with_aging dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .wing_key      (wing_key),
        .room_key      (room_key),
        .bed_key       (bed_key),
        .patient_key   (patient_key),
        .kind_key      (kind_key),
        .now_ms        (now_ms),
        .done          (done),
        .status        (status),
        .slot          (slot),
        .expired_count (expired_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // results are sampled at the edge that ends their cycle, pre-edge values
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(status, slot, expired_count);
    end

    // watchdog: any accepted item, result or register write restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic table_request_t make_request(input logic act,
                                                    input logic [KEY_W-1:0] k,
                                                    input logic [TIME_W-1:0] t);
        table_request_t req;
        req.action = act;
        {req.wing_key, req.room_key, req.bed_key, req.patient_key, req.kind_key} = k;
        req.now_ms = t;
        return req;
    endfunction

    // mostly back to back, often a short pause, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 20);
        else
            return $urandom_range(30, 80);
    endfunction

    // present one item, holding start high until the block takes it;
    // start is only lowered when a gap is wanted, so it never toggles in one step
    task automatic issue_request(input table_request_t req, input int unsigned gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        action      <= req.action;
        wing_key    <= req.wing_key;
        room_key    <= req.room_key;
        bed_key     <= req.bed_key;
        patient_key <= req.patient_key;
        kind_key    <= req.kind_key;
        now_ms      <= req.now_ms;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(req);
    endtask

    // block is idle once every owed result is in and busy has dropped
    task automatic wait_idle();
        start <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending_results.size() != 0 || busy);
        @(posedge clk);
    endtask

    task automatic write_timeout(input logic [TIME_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_timeout(value);
        cfg_valid <= 1'b0;
    endtask

    // directed walk through fill, full table, age boundary, stale hit and full sweep
    task automatic run_directed();
        logic [KEY_W-1:0] k;
        // all-zero key claims slot 0, then hits it
        issue_request(make_request(ACT_LOOKUP, '0, 32'd0), pick_gap());
        issue_request(make_request(ACT_LOOKUP, '0, 32'd100), pick_gap());
        // all-ones key stamped at the top of the time range
        issue_request(make_request(ACT_LOOKUP, '1, 32'hFFFF_FFFF), pick_gap());
        // fill the rest of the table at time zero
        for (int i = 2; i < ENTRIES; i++)
        begin
            k = {8'(i), 8'hA5, 8'h5A, ~8'(i), 8'(i)};
            issue_request(make_request(ACT_LOOKUP, k, 32'd0), pick_gap());
        end
        // table full
        issue_request(make_request(ACT_LOOKUP, 40'h12_3456_789A, 32'd1), pick_gap());
        // age equal to the timeout is kept, the wrapped stamp is one over and goes
        issue_request(make_request(ACT_SWEEP, {$urandom, 8'($urandom)}, 32'd5000),
                      pick_gap());
        // stale entry is still found until a sweep frees it
        issue_request(make_request(ACT_LOOKUP, '0, 32'd7000), pick_gap());
        // lowest free slot is reused
        issue_request(make_request(ACT_LOOKUP, 40'h01_0203_0405, 32'd7000), pick_gap());
        // every entry expires at once
        issue_request(make_request(ACT_SWEEP, '1, 32'd12001), pick_gap());
        // sweep of an empty table
        issue_request(make_request(ACT_SWEEP, {$urandom, 8'($urandom)}, $urandom),
                      pick_gap());
    endtask

    // random traffic: lookups on a small key pool so hits, fills and full
    // tables all happen, with sweeps mixed in and time moving mostly forward
    task automatic run_traffic(input int count, input bit steady);
        table_request_t   req;
        logic [KEY_W-1:0] k;
        int unsigned      r;
        int unsigned      idx;
        for (int p = 0; p < POOL; p++)
            key_pool[p] = {$urandom, 8'($urandom)};
        clock_ms = $urandom;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 85)
                k = key_pool[$urandom_range(0, POOL - 1)];
            else
                k = {$urandom, 8'($urandom)};
            r = $urandom_range(0, 99);
            if (r < 45)
                clock_ms = clock_ms + $urandom_range(0, 3);
            else if (r < 75)
                clock_ms = clock_ms + $urandom_range(0, 2000);
            else if (r < 92)
                clock_ms = clock_ms + $urandom_range(0, 20000);
            else
                clock_ms = $urandom;
            req = make_request(($urandom_range(0, 99) < 18) ? ACT_SWEEP : ACT_LOOKUP,
                               k, clock_ms);
            // some sweeps land right on the age limit of a stored entry
            if (req.action == ACT_SWEEP && $urandom_range(0, 2) == 0)
            begin
                idx = $urandom_range(0, ENTRIES - 1);
                if (sb.live[idx])
                begin
                    clock_ms   = sb.stamp[idx] + sb.timeout_ms + $urandom_range(0, 1);
                    req.now_ms = clock_ms;
                end
            end
            issue_request(req, steady ? 0 : pick_gap());
        end
    endtask

    initial
    begin
        logic [TIME_W-1:0] settings [6];
        sb = new();
        // timeout per random phase: both extremes, tiny, reset value, anything, moderate
        settings[0] = '0;
        settings[1] = '1;
        settings[2] = 32'd1;
        settings[3] = TIMEOUT_RESET;
        settings[4] = $urandom;
        settings[5] = $urandom_range(100, 3000);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part runs on the reset value of the timeout
        run_directed();

        for (int ph = 0; ph < 6; ph++)
        begin
            wait_idle();
            write_timeout(settings[ph]);
            // one phase keeps the command side saturated
            run_traffic(96, ph == 3);
        end

        wait_idle();
        repeat (ENTRIES + 8) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
